[hdl/pae_pkg.sv]
`default_nettype none
package pae_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int POS_BITS  = $clog2(DEPTH);
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    ACT_READ   = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_INSERT = 2'd2,
    ACT_DELETE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [3:0]         position;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] data;
    status_t            status;
    logic [4:0]         fill_count;
  } out_item_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic                wr;
    logic                ins;
    logic                del;
    logic [POS_BITS-1:0] pos;
    logic [CNT_BITS-1:0] cnt;
    word_t               value;
  } cell_cmd_t;

endpackage
`default_nettype wire

[hdl/pae_cell.sv]
`default_nettype none
module pae_cell (
  input  wire                           clk,
  input  wire pae_pkg::cell_cmd_t       cmd,
  input  wire [pae_pkg::POS_BITS-1:0]   idx,
  input  wire pae_pkg::word_t           left_word,
  input  wire pae_pkg::word_t           right_word,
  output pae_pkg::word_t                word
);

  pae_pkg::word_t                word_r;
  pae_pkg::word_t                word_nxt;
  logic [pae_pkg::CNT_BITS-1:0]  idx_ext;

  assign idx_ext = pae_pkg::CNT_BITS'(idx);

  always_comb begin
    word_nxt = word_r;
    if ((cmd.wr || cmd.ins) && idx == cmd.pos) begin
      word_nxt = cmd.value;
    end else if (cmd.ins && idx > cmd.pos && idx_ext <= cmd.cnt) begin
      word_nxt = left_word;
    end else if (cmd.del && idx > cmd.pos &&
                 idx_ext < cmd.cnt) begin
      word_nxt = word_r;
    end
    if (cmd.del && idx >= cmd.pos &&
        (idx_ext + pae_pkg::CNT_BITS'(1)) < cmd.cnt) begin
      word_nxt = right_word;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule
`default_nettype wire

[hdl/pae_ctrl.sv]
`default_nettype none
module pae_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     accept,
  input  wire pae_pkg::in_item_t  in_item,
  input  wire pae_pkg::word_t     rd_word,
  output pae_pkg::cell_cmd_t      cmd,
  output logic                    out_valid,
  output pae_pkg::out_item_t      out_item
);

  logic [pae_pkg::CNT_BITS-1:0] count_r;
  logic [pae_pkg::CNT_BITS-1:0] count_nxt;
  logic                         out_valid_r;
  pae_pkg::out_item_t           out_item_r;
  pae_pkg::out_item_t           out_item_nxt;
  pae_pkg::action_t             act;
  logic [pae_pkg::CNT_BITS-1:0] pos_ext;
  logic                         ok;

  assign act     = pae_pkg::action_t'(in_item.action);
  assign pos_ext = pae_pkg::CNT_BITS'(in_item.position);

  always_comb begin
    ok                      = 1'b0;
    count_nxt               = count_r;
    out_item_nxt.data       = '0;
    out_item_nxt.status     = pae_pkg::ST_DONE;
    if (act == pae_pkg::ACT_INSERT) begin
      if (count_r >= pae_pkg::CNT_BITS'(pae_pkg::DEPTH)) begin
        out_item_nxt.status = pae_pkg::ST_FULL;
      end else if (pos_ext > count_r) begin
        out_item_nxt.status = pae_pkg::ST_RANGE;
      end else begin
        ok        = 1'b1;
        count_nxt = count_r + pae_pkg::CNT_BITS'(1);
        if (pos_ext < count_r) begin
          out_item_nxt.data = rd_word;
        end
      end
    end else if (pos_ext >= count_r) begin
      out_item_nxt.status = pae_pkg::ST_RANGE;
    end else begin
      ok                = 1'b1;
      out_item_nxt.data = rd_word;
      if (act == pae_pkg::ACT_DELETE) begin
        count_nxt = count_r - pae_pkg::CNT_BITS'(1);
      end
    end
    out_item_nxt.fill_count = accept ? count_nxt : count_r;

    cmd.wr    = accept && ok && act == pae_pkg::ACT_WRITE;
    cmd.ins   = accept && ok && act == pae_pkg::ACT_INSERT;
    cmd.del   = accept && ok && act == pae_pkg::ACT_DELETE;
    cmd.pos   = in_item.position;
    cmd.cnt   = count_r;
    cmd.value = in_item.value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= pae_pkg::CNT_BITS'(pae_pkg::DEPTH))
    else $error("fill count above depth");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted transfer without result");

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_item_r.fill_count == count_r)
    else $error("reported count differs from held count");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.status != pae_pkg::ST_DONE |->
      out_item_r.data == '0 && $stable(count_r))
    else $error("rejected request changed state or returned data");

endmodule
`default_nettype wire

[hdl/positional_array_editor_unit.sv]
`default_nettype none
// Positional array editor: a packed list of up to 16 signed words with read, overwrite,
// insert and delete at a position. A request is taken whenever start is high and busy
// is low; busy is high only while reset is held, so a new request may follow every
// cycle. Each request gives exactly one result, shown with out_valid for one cycle,
// the cycle after the request; the receiver cannot stall and must take it then. All
// entries move together through a row of register cells, each loading from itself,
// its neighbor or the request word.
module positional_array_editor_unit (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     start,
  output logic                    busy,
  input  wire pae_pkg::in_item_t  in_item,
  output logic                    out_valid,
  output pae_pkg::out_item_t      out_item
);

  pae_pkg::cell_cmd_t cmd;
  pae_pkg::word_t     cell_word [pae_pkg::DEPTH];
  pae_pkg::word_t     rd_word;
  logic               accept;

  assign busy    = !rst_n;
  assign accept  = start && !busy;
  assign rd_word = cell_word[in_item.position[pae_pkg::POS_BITS-1:0]];

  pae_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_item),
    .rd_word   (rd_word),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  for (genvar g = 0; g < pae_pkg::DEPTH; g++) begin : g_cell
    pae_pkg::word_t left_w;
    pae_pkg::word_t right_w;
    if (g == 0) begin : g_first
      assign left_w = cell_word[g];
    end else begin : g_mid_l
      assign left_w = cell_word[g-1];
    end
    if (g == pae_pkg::DEPTH - 1) begin : g_last
      assign right_w = cell_word[g];
    end else begin : g_mid_r
      assign right_w = cell_word[g+1];
    end
    pae_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .idx        (pae_pkg::POS_BITS'(g)),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (cell_word[g])
    );
  end

endmodule
`default_nettype wire

[verif/tb_top.sv]
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pae_pkg::*;

  localparam int STALL_LIMIT = 500;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;

  word_t     list_words [DEPTH];
  int        list_count;
  out_item_t expected_results [$];
  out_item_t want;
  int        error_count;
  int        stall_cycles;
  bit        allow_gaps;

  positional_array_editor_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // updates the shadow list and gives the result of one edit request
  function automatic out_item_t apply_edit(input in_item_t req);
    out_item_t res;
    action_t   act;
    int        pos;
    int        i;
    res.data   = '0;
    res.status = ST_DONE;
    act = action_t'(req.action);
    pos = int'(req.position);
    if (act == ACT_INSERT) begin
      if (list_count >= DEPTH) begin
        res.status = ST_FULL;
      end else if (pos > list_count) begin
        res.status = ST_RANGE;
      end else begin
        if (pos < list_count) res.data = list_words[pos];
        for (i = list_count; i > pos; i--) list_words[i] = list_words[i-1];
        list_words[pos] = req.value;
        list_count++;
      end
    end else if (pos >= list_count) begin
      res.status = ST_RANGE;
    end else begin
      res.data = list_words[pos];
      if (act == ACT_WRITE) begin
        list_words[pos] = req.value;
      end else if (act == ACT_DELETE) begin
        for (i = pos; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
        list_count--;
      end
    end
    res.fill_count = 5'(list_count);
    return res;
  endfunction

  function automatic in_item_t edit(input action_t act, input int pos, input word_t val);
    in_item_t req;
    req.action   = act;
    req.position = 4'(pos);
    req.value    = val;
    return req;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(4, 20);
  endfunction

  // mostly well-formed edits at valid positions, some noise
  function automatic in_item_t make_edit(input int grow_pct);
    in_item_t req;
    action_t  act;
    int       pick;
    int       top_pos;
    req.value = $urandom;
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0:       req.value = 32'sh8000_0000;
        1:       req.value = 32'sh7fff_ffff;
        2:       req.value = '0;
        default: req.value = -1;
      endcase
    end
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      req.action   = 2'($urandom_range(0, 3));
      req.position = 4'($urandom_range(0, 15));
    end else begin
      if (pick < 23) act = ACT_READ;
      else if (pick < 38) act = ACT_WRITE;
      else if ($urandom_range(0, 99) < grow_pct) act = ACT_INSERT;
      else act = ACT_DELETE;
      if (act == ACT_INSERT) top_pos = (list_count >= DEPTH) ? DEPTH - 1 : list_count;
      else top_pos = (list_count == 0) ? DEPTH - 1 : list_count - 1;
      req.action = act;
      case ($urandom_range(0, 3))
        0:       req.position = '0;
        1:       req.position = 4'(top_pos);
        default: req.position = 4'($urandom_range(0, top_pos));
      endcase
    end
    return req;
  endfunction

  task automatic send_edit(input in_item_t req);
    int gap;
    gap = allow_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item <= req;
    start   <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    expected_results.push_back(apply_edit(req));
  endtask

  task automatic test_range_on_empty();
    send_edit(edit(ACT_READ, 0, 32'sd5));
    send_edit(edit(ACT_WRITE, 15, 32'sh7fff_ffff));
    send_edit(edit(ACT_DELETE, 15, 32'sd0));
    send_edit(edit(ACT_INSERT, 1, 32'sd7));
  endtask

  task automatic test_fill_to_full();
    int k;
    send_edit(edit(ACT_INSERT, 0, 32'sh8000_0000));
    send_edit(edit(ACT_INSERT, 1, 32'sh7fff_ffff));
    send_edit(edit(ACT_INSERT, 0, -1));
    send_edit(edit(ACT_INSERT, 1, 32'sd0));
    for (k = 4; k < DEPTH; k++) begin
      send_edit(edit(ACT_INSERT, (k % 3 == 0) ? 0 : k,
                     word_t'(k[0] ? 32'h5555_5555 ^ k : 32'haaaa_aaaa ^ k)));
    end
  endtask

  task automatic test_edits_when_full();
    send_edit(edit(ACT_INSERT, 0, 32'sd1));
    send_edit(edit(ACT_INSERT, 15, 32'sd2));
    send_edit(edit(ACT_READ, 15, 32'sd3));
    send_edit(edit(ACT_WRITE, 15, 32'sh8000_0000));
    send_edit(edit(ACT_DELETE, 0, 32'sd4));
    send_edit(edit(ACT_DELETE, 14, 32'sd5));
  endtask

  task automatic test_random_edits(input int num_items, input int grow_pct, input bit gaps);
    allow_gaps = gaps;
    repeat (num_items) send_edit(make_edit(grow_pct));
  endtask

  task automatic drain_and_finish();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  endtask

  // result check: each transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $realtime, out_item);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_item.data !== want.data) begin
          $display("%0t: data mismatch, expected %0d actual %0d",
                   $realtime, want.data, out_item.data);
          error_count++;
        end
        if (out_item.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $realtime, want.status, out_item.status);
          error_count++;
        end
        if (out_item.fill_count !== want.fill_count) begin
          $display("%0t: fill_count mismatch, expected %0d actual %0d",
                   $realtime, want.fill_count, out_item.fill_count);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    error_count  = 0;
    stall_cycles = 0;
    list_count   = 0;
    allow_gaps   = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_range_on_empty();
    test_fill_to_full();
    test_edits_when_full();
    test_random_edits(450, 75, 1'b1);
    test_random_edits(450, 25, 1'b1);
    test_random_edits(450, 50, 1'b0);
    test_random_edits(450, 50, 1'b1);
    drain_and_finish();
  end

endmodule
`default_nettype wire

[sim.f]
hdl/pae_pkg.sv
hdl/pae_cell.sv
hdl/pae_ctrl.sv
hdl/positional_array_editor_unit.sv
verif/tb_top.sv
